FILE: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// Status frame receiver package
// Shared types and constants for the status frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned NibW       = 4;
  localparam int unsigned CountW     = 16;
  localparam int unsigned FrameBytes = 8;
  localparam int unsigned IdxW       = $clog2(FrameBytes);
  localparam int unsigned CfgIdxW    = 1;

  // Byte positions inside a frame, counting from zero.
  localparam logic [IdxW-1:0] InStatusIdx  = IdxW'(4);
  localparam logic [IdxW-1:0] OutStatusIdx = IdxW'(6);
  localparam logic [IdxW-1:0] CheckIdx     = IdxW'(FrameBytes - 1);

  localparam logic [ByteW-1:0] TimeoutReset = ByteW'(20);
  localparam logic [ByteW-1:0] HeaderReset  = ByteW'(8'h22);

  typedef enum logic [CfgIdxW-1:0] {
    CfgTimeout = 1'b0,
    CfgHeader  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic [TimeW-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic              checksum_ok;
    logic [NibW-1:0]   input_status;
    logic [NibW-1:0]   output_status;
    logic [CountW-1:0] good_frames;
  } out_item_t;

  typedef struct packed {
    logic [ByteW-1:0] interbyte_timeout_ms;
    logic [ByteW-1:0] header_byte;
  } cfg_t;

endpackage

FILE: rtl/sfr_frame_core.sv
// ----------------------------------------------------------------------------
// Status frame receiver core
// Frame state and the per-byte update: timeout, header, sum check, latching.
// ----------------------------------------------------------------------------
module sfr_frame_core import sfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  logic [IdxW-1:0]   idx_q, idx_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [TimeW-1:0]  last_q, last_d;
  logic [NibW-1:0]   pin_q, pin_d;
  logic [NibW-1:0]   pout_q, pout_d;
  logic [NibW-1:0]   hin_q, hin_d;
  logic [NibW-1:0]   hout_q, hout_d;
  logic [CountW-1:0] good_q, good_d;

  logic [TimeW-1:0]  gap;
  logic              timed_out;
  logic [IdxW-1:0]   idx_eff;
  logic [ByteW-1:0]  sum_eff;
  logic [NibW-1:0]   pin_eff;
  logic [NibW-1:0]   pout_eff;
  logic              drop_byte;
  logic              sum_ok;

  // The gap wraps with the tick counter, so a plain subtraction is enough.
  assign gap       = item_i.now_ms - last_q;
  assign timed_out = gap > TimeW'(cfg_i.interbyte_timeout_ms);

  assign idx_eff  = timed_out ? '0 : idx_q;
  assign sum_eff  = timed_out ? '0 : sum_q;
  assign pin_eff  = timed_out ? '0 : pin_q;
  assign pout_eff = timed_out ? '0 : pout_q;

  assign drop_byte = (idx_eff == '0) && (item_i.rx_byte != cfg_i.header_byte);
  assign sum_ok    = item_i.rx_byte == sum_eff;

  always_comb begin
    idx_d       = idx_q;
    sum_d       = sum_q;
    last_d      = last_q;
    pin_d       = pin_q;
    pout_d      = pout_q;
    hin_d       = hin_q;
    hout_d      = hout_q;
    good_d      = good_q;
    res_valid_o = 1'b0;
    if (step_i) begin
      last_d = item_i.now_ms;
      idx_d  = idx_eff;
      sum_d  = sum_eff;
      pin_d  = pin_eff;
      pout_d = pout_eff;
      if (!drop_byte) begin
        if (idx_eff != CheckIdx) begin
          if (idx_eff == InStatusIdx) begin
            pin_d = item_i.rx_byte[NibW-1:0];
          end
          if (idx_eff == OutStatusIdx) begin
            pout_d = item_i.rx_byte[NibW-1:0];
          end
          sum_d = sum_eff + item_i.rx_byte;
          idx_d = idx_eff + IdxW'(1);
        end else begin
          res_valid_o = 1'b1;
          if (sum_ok) begin
            hin_d  = pin_eff;
            hout_d = pout_eff;
            good_d = good_q + CountW'(1);
          end
          idx_d  = '0;
          sum_d  = '0;
          pin_d  = '0;
          pout_d = '0;
        end
      end
    end
  end

  always_comb begin
    res_o.checksum_ok   = sum_ok;
    res_o.input_status  = hin_d;
    res_o.output_status = hout_d;
    res_o.good_frames   = good_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      sum_q  <= '0;
      last_q <= '0;
      pin_q  <= '0;
      pout_q <= '0;
      hin_q  <= '0;
      hout_q <= '0;
      good_q <= '0;
    end else begin
      idx_q  <= idx_d;
      sum_q  <= sum_d;
      last_q <= last_d;
      pin_q  <= pin_d;
      pout_q <= pout_d;
      hin_q  <= hin_d;
      hout_q <= hout_d;
      good_q <= good_d;
    end
  end

  // A completed frame always leaves the assembler at frame start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o |=> idx_q == '0)
    else $error("frame index not cleared after a completed frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.checksum_ok |=> good_q == $past(good_q) + CountW'(1))
    else $error("good-frame counter did not advance on a good frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i && res_valid_o && res_o.checksum_ok) |=>
      $stable(good_q) && $stable(hin_q) && $stable(hout_q))
    else $error("latched status changed without a good frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(idx_q) && $stable(last_q) && $stable(sum_q))
    else $error("frame state changed without a byte");

endmodule

FILE: rtl/status_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// Status frame receiver
// Assembles eight-byte status frames from timestamped bytes and reports
// the checksum result and latched status for every completed frame.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle unless a waiting result holds the flow. A
// byte lands in an input register, the frame state is updated from it when
// that register advances, and a completed frame's result is loaded into an
// output register at that same edge. While a result waits, the input side
// takes a byte only if the input register is empty; in_ready_o follows
// out_ready_i combinationally when both registers are full. There is no
// clearing pass after reset. Configuration is written through a plain write
// port and should only be changed while no byte is in flight.
module status_frame_receiver_unit import sfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i
);

  logic      in_valid_q, in_valid_d;
  in_item_t  in_data_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;
  cfg_t      cfg_q, cfg_d;

  logic      advance;
  logic      res_valid;
  out_item_t res;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgTimeout: cfg_d.interbyte_timeout_ms = cfg_wdata_i;
        CfgHeader:  cfg_d.header_byte          = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q                 <= 1'b0;
      out_valid_q                <= 1'b0;
      cfg_q.interbyte_timeout_ms <= TimeoutReset;
      cfg_q.header_byte          <= HeaderReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (advance && res_valid) begin
      out_data_q <= res;
    end
  end

  sfr_frame_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (in_data_q),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Status frame receiver testbench
// Sends timestamped bytes, mostly whole frames with random content and some
// noise, under several register settings and idle patterns. A built-in
// predictor tracks the frame state and each frame report is checked in order.
// ----------------------------------------------------------------------------
module tb;
  import sfr_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned MaxShown   = 10;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_data_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ByteW-1:0]   cfg_wdata_i;

  status_frame_receiver_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Predicted receiver state and register copies.
  logic [ByteW-1:0]  timeout_ms;
  logic [ByteW-1:0]  header_val;
  logic [IdxW-1:0]   frame_pos;
  logic [ByteW-1:0]  frame_sum;
  logic [TimeW-1:0]  prev_ms;
  logic [NibW-1:0]   part_in;
  logic [NibW-1:0]   part_out;
  logic [NibW-1:0]   held_in;
  logic [NibW-1:0]   held_out;
  logic [CountW-1:0] good_cnt;

  out_item_t         due_reports[$];
  logic [TimeW-1:0]  wall_ms;
  int unsigned       bytes_sent;
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  logic              hold_start;
  int unsigned       stall_left = 0;
  int unsigned       cycle_count = 0;
  int unsigned       mismatch_count = 0;

  function automatic void clear_partial();
    frame_pos = '0;
    frame_sum = '0;
    part_in   = '0;
    part_out  = '0;
  endfunction

  function automatic void track_byte(logic [ByteW-1:0] b, logic [TimeW-1:0] t);
    logic [TimeW-1:0] gap;
    out_item_t        rep;
    gap = t - prev_ms;
    if (gap > TimeW'(timeout_ms)) clear_partial();
    prev_ms = t;
    if (frame_pos == '0 && b != header_val) return;
    if (frame_pos != CheckIdx) begin
      if (frame_pos == InStatusIdx) part_in = b[NibW-1:0];
      if (frame_pos == OutStatusIdx) part_out = b[NibW-1:0];
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 1'b1;
      return;
    end
    rep.checksum_ok = (b == frame_sum);
    if (rep.checksum_ok) begin
      held_in  = part_in;
      held_out = part_out;
      good_cnt = good_cnt + 1'b1;
    end
    clear_partial();
    rep.input_status  = held_in;
    rep.output_status = held_out;
    rep.good_frames   = good_cnt;
    due_reports.push_back(rep);
  endfunction

  // A gap that keeps the frame alive, or one that is just or far beyond the timeout.
  function automatic logic [TimeW-1:0] ms_gap(bit late);
    logic [TimeW-1:0] gap;
    if (late) begin
      case ($urandom_range(2))
        0: gap = TimeW'(timeout_ms) + 1;
        1: gap = TimeW'(timeout_ms) + 1 + $urandom_range(0, 300);
        default: gap = TimeW'(timeout_ms) + 1 + $urandom_range(0, 32'hFFFF_0000);
      endcase
    end else if ($urandom_range(3) == 0) begin
      gap = TimeW'(timeout_ms);
    end else begin
      gap = $urandom_range(0, timeout_ms);
    end
    return gap;
  endfunction

  // Valid stays high after a transfer; it is lowered only when an idle gap follows.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic [TimeW-1:0] t);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{rx_byte: b, now_ms: t};
    do @(posedge clk_i); while (!in_ready_o);
    track_byte(b, t);
    bytes_sent++;
  endtask

  task automatic send_timed(input logic [ByteW-1:0] b, input bit late, input int fixed_gap);
    if (late) wall_ms = wall_ms + ms_gap(1'b1);
    else if (fixed_gap >= 0) wall_ms = wall_ms + TimeW'(fixed_gap);
    else wall_ms = wall_ms + ms_gap(1'b0);
    send_byte(b, wall_ms);
  endtask

  // late_pos picks the byte that arrives after a timeout; -1 means none.
  task automatic send_frame(input logic [ByteW-1:0] body [6], input bit bad_check,
                            input int late_pos, input int fixed_gap);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    sum = header_val;
    for (int i = 0; i < FrameBytes; i++) begin
      if (i == 0) b = header_val;
      else if (i < FrameBytes - 1) b = body[i-1];
      else b = bad_check ? sum + ByteW'($urandom_range(1, 255)) : sum;
      if (i > 0 && i < FrameBytes - 1) sum = sum + b;
      send_timed(b, i == late_pos, fixed_gap);
    end
  endtask

  task automatic send_noise();
    int unsigned n;
    logic [ByteW-1:0] b;
    n = $urandom_range(1, 4);
    repeat (n) begin
      b = ($urandom_range(3) == 0) ? header_val : ByteW'($urandom);
      if ($urandom_range(4) == 0) begin
        wall_ms = $urandom;
        send_byte(b, wall_ms);
      end else begin
        send_timed(b, $urandom_range(1), -1);
      end
    end
  endtask

  task automatic run_random(input int unsigned n_bytes);
    int unsigned target;
    int unsigned pick;
    logic [ByteW-1:0] body [6];
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      foreach (body[k]) body[k] = ByteW'($urandom);
      if (pick < 60) send_frame(body, 1'b0, -1, -1);
      else if (pick < 75) send_frame(body, 1'b1, -1, -1);
      else if (pick < 85) send_frame(body, $urandom_range(1), $urandom_range(0, 7), -1);
      else send_noise();
    end
  endtask

  // Lets every expected report drain and the pipeline settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [ByteW-1:0] timeout, input logic [ByteW-1:0] header);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgTimeout;
    cfg_wdata_i <= timeout;
    @(posedge clk_i);
    cfg_idx_i   <= CfgHeader;
    cfg_wdata_i <= header;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_ms = timeout;
    header_val = header;
  endtask

  // Reset register values: a clean frame, a stray byte, a frame cut by a
  // timeout, and a bad frame whose timestamps wrap through zero.
  task automatic test_directed();
    logic [ByteW-1:0] body [6];
    idle_pct = 0;
    body = '{8'hFF, 8'h00, 8'h80, 8'h5A, 8'h01, 8'hC3};
    send_frame(body, 1'b0, -1, 20);
    send_timed(8'h23, 1'b0, 5);
    send_timed(header_val, 1'b0, 1);
    send_timed(8'h11, 1'b0, 1);
    send_timed(8'h12, 1'b0, 1);
    wall_ms = 32'hFFFF_FFF0;
    body = '{8'h7F, 8'hFE, 8'h3C, 8'hA5, 8'h0F, 8'hF0};
    send_frame(body, 1'b1, -1, 3);
  endtask

  task automatic test_config_sweep();
    logic [ByteW-1:0] timeouts [4];
    logic [ByteW-1:0] headers [4];
    timeouts = '{8'd0, 8'd255, ByteW'($urandom), TimeoutReset};
    headers  = '{8'hFF, 8'h00, ByteW'($urandom), HeaderReset};
    idle_pct  = 30;
    stall_pct <= 30;
    foreach (timeouts[k]) begin
      set_config(timeouts[k], headers[k]);
      run_random(35);
    end
  endtask

  task automatic test_idle_phases();
    int unsigned senders [4];
    int unsigned stalls [4];
    senders = '{0, 50, 0, 30};
    stalls  = '{0, 0, 50, 30};
    foreach (senders[k]) begin
      idle_pct  = senders[k];
      stall_pct <= stalls[k];
      run_random(110);
    end
  endtask

  // The receiver holds off while whole frames keep coming, so the input stalls.
  task automatic test_backpressure();
    logic [ByteW-1:0] body [6];
    drain();
    idle_pct   = 0;
    stall_pct  <= 0;
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    repeat (6) begin
      foreach (body[k]) body[k] = ByteW'($urandom);
      send_frame(body, 1'b0, -1, -1);
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      if (hold_start) stall_left = HoldCycles;
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (due_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxShown)
            $display("unexpected report: ok=%0d in=%h out=%h good=%0d",
                     out_data_o.checksum_ok, out_data_o.input_status,
                     out_data_o.output_status, out_data_o.good_frames);
        end else begin
          want = due_reports.pop_front();
          if (out_data_o.checksum_ok !== want.checksum_ok ||
              out_data_o.input_status !== want.input_status ||
              out_data_o.output_status !== want.output_status ||
              out_data_o.good_frames !== want.good_frames) begin
            mismatch_count++;
            if (mismatch_count <= MaxShown)
              $display({"report mismatch: expected ok=%0d in=%h out=%h good=%0d, ",
                        "got ok=%0d in=%h out=%h good=%0d"},
                       want.checksum_ok, want.input_status, want.output_status,
                       want.good_frames, out_data_o.checksum_ok, out_data_o.input_status,
                       out_data_o.output_status, out_data_o.good_frames);
          end
        end
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CfgTimeout;
    cfg_wdata_i <= '0;
    hold_start  <= 1'b0;
    stall_pct   <= 0;
    bytes_sent     = 0;
    wall_ms        = '0;
    prev_ms        = '0;
    held_in        = '0;
    held_out       = '0;
    good_cnt       = '0;
    timeout_ms     = TimeoutReset;
    header_val     = HeaderReset;
    clear_partial();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config_sweep();
    test_idle_phases();
    test_backpressure();

    drain();
    stall_pct <= 0;
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && due_reports.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/sfr_pkg.sv
rtl/sfr_frame_core.sv
rtl/status_frame_receiver_unit.sv
verif/tb.sv
